// ===== rtl/core/wds_pkg.sv =====
// Shared types, codes and widths of the weight dosing sequencer.
`timescale 1ns / 1ps

package wds_pkg;

   // Scale reading width in 0.01 g units.
   localparam int WEIGHT_BITS = 24;
   // One bit more holds any difference of two readings, either sign.
   localparam int DIFF_BITS   = WEIGHT_BITS + 1;
   localparam int GOAL_BITS   = 23;
   localparam int DELIV_BITS  = 24;
   localparam int ELAPSED_BITS = 32;
   localparam int SECONDS_BITS = 16;
   // Widest value of seconds times 1000.
   localparam int LIMIT_BITS  = 26;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 23;

   localparam logic [LIMIT_BITS-1:0] MS_PER_SEC = LIMIT_BITS'(1000);

   // Request kinds.
   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_TURN  = 2'd1;
   localparam logic [1:0] KIND_FINAL = 2'd2;

   // Result actions.
   localparam logic [1:0] ACT_NONE    = 2'd0;
   localparam logic [1:0] ACT_FORWARD = 2'd1;
   localparam logic [1:0] ACT_STOP    = 2'd2;
   localparam logic [1:0] ACT_REPORT  = 2'd3;

   // Dose status codes.
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOSCALE = 2'd1;
   localparam logic [1:0] ST_TIMEOUT = 2'd2;
   localparam logic [1:0] ST_NOFOOD  = 2'd3;

   // Dose phases.
   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_DOSING = 2'd1;
   localparam logic [1:0] PH_FINAL  = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SENSING_MODE = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TIMEOUT      = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_GAIN     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STALL_TURNS  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_RETRACTS = 3'd4;

   localparam logic [SECONDS_BITS-1:0] TIMEOUT_RESET  = 16'd60;
   localparam logic [GOAL_BITS-1:0]    MIN_GAIN_RESET = 23'd50;
   localparam logic [2:0]              STALL_RESET    = 3'd4;
   localparam logic [2:0]              RETRACT_RESET  = 3'd3;

   typedef struct packed {
      logic                    sensing_mode;
      logic [LIMIT_BITS-1:0]   limit_ms;
      logic [GOAL_BITS-1:0]    min_gain;
      logic [2:0]              stall_turns;
      logic [2:0]              max_retracts;
   } cfg_type;

   typedef struct packed {
      logic [1:0]                     kind;
      logic signed [WEIGHT_BITS-1:0]  weight;
      logic                           weight_valid;
      logic [GOAL_BITS-1:0]           target_amount;
      logic [ELAPSED_BITS-1:0]        elapsed_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]            action;
      logic                  reverse_first;
      logic [1:0]            status;
      logic [DELIV_BITS-1:0] delivered;
   } rsp_type;

endpackage

// ===== rtl/core/wds_csr.sv =====
// Configuration registers of the dosing sequencer.
`timescale 1ns / 1ps

module wds_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   input  logic [wds_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [wds_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output wds_pkg::cfg_type                   cfg
);

   wds_pkg::cfg_type             cfg_ff;
   wds_pkg::cfg_type             cfg_in;
   logic [wds_pkg::LIMIT_BITS-1:0] limit_ms;

   // The timeout is kept in milliseconds so the datapath only compares.
   assign limit_ms = wds_pkg::LIMIT_BITS'(csr_wdata[wds_pkg::SECONDS_BITS-1:0])
                     * wds_pkg::MS_PER_SEC;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            wds_pkg::CSR_SENSING_MODE: cfg_in.sensing_mode = csr_wdata[0];
            wds_pkg::CSR_TIMEOUT:      cfg_in.limit_ms     = limit_ms;
            wds_pkg::CSR_MIN_GAIN:     cfg_in.min_gain     = csr_wdata;
            wds_pkg::CSR_STALL_TURNS:  cfg_in.stall_turns  = csr_wdata[2:0];
            wds_pkg::CSR_MAX_RETRACTS: cfg_in.max_retracts = csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sensing_mode <= 1'b0;
         cfg_ff.limit_ms     <= wds_pkg::LIMIT_BITS'(wds_pkg::TIMEOUT_RESET)
                                * wds_pkg::MS_PER_SEC;
         cfg_ff.min_gain     <= wds_pkg::MIN_GAIN_RESET;
         cfg_ff.stall_turns  <= wds_pkg::STALL_RESET;
         cfg_ff.max_retracts <= wds_pkg::RETRACT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/wds_ctrl.sv =====
// Dose state registers and the per-request decision logic.
`timescale 1ns / 1ps

module wds_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  wds_pkg::req_type req,
   input  wds_pkg::cfg_type cfg,
   output wds_pkg::rsp_type rsp
);

   logic [1:0]                               phase_ff, phase_in;
   logic signed [wds_pkg::WEIGHT_BITS-1:0]   tare_ff, tare_in;
   logic signed [wds_pkg::WEIGHT_BITS-1:0]   prev_ff, prev_in;
   logic [wds_pkg::GOAL_BITS-1:0]            goal_ff, goal_in;
   logic signed [wds_pkg::DIFF_BITS-1:0]     run_ff, run_in;
   logic [2:0]                               ngc_ff, ngc_in;
   logic [2:0]                               rc_ff, rc_in;
   logic [1:0]                               dstat_ff, dstat_in;

   logic signed [wds_pkg::DIFF_BITS-1:0]     diff_tare, diff_prev;
   logic signed [wds_pkg::DIFF_BITS-1:0]     gain_tare, gain_prev;
   logic signed [wds_pkg::DIFF_BITS-1:0]     min_gain_s;
   logic                                     timed_out;

   // In hopper mode the weight falls as food leaves, so differences flip sign.
   assign diff_tare = wds_pkg::DIFF_BITS'(req.weight) - wds_pkg::DIFF_BITS'(tare_ff);
   assign diff_prev = wds_pkg::DIFF_BITS'(req.weight) - wds_pkg::DIFF_BITS'(prev_ff);
   assign gain_tare = cfg.sensing_mode ? -diff_tare : diff_tare;
   assign gain_prev = cfg.sensing_mode ? -diff_prev : diff_prev;
   assign min_gain_s = $signed({2'b00, cfg.min_gain});
   assign timed_out = req.elapsed_ms > wds_pkg::ELAPSED_BITS'(cfg.limit_ms);

   always_comb begin
      logic       do_head;
      logic       rev;
      logic [2:0] ngc_inc;
      logic [3:0] rc_inc;

      do_head  = 1'b0;
      rev      = 1'b0;
      ngc_inc  = ngc_ff + 3'd1;
      rc_inc   = {1'b0, rc_ff} + 4'd1;
      phase_in = phase_ff;
      tare_in  = tare_ff;
      prev_in  = prev_ff;
      goal_in  = goal_ff;
      run_in   = run_ff;
      ngc_in   = ngc_ff;
      rc_in    = rc_ff;
      dstat_in = dstat_ff;
      rsp      = '0;

      if (req.kind == wds_pkg::KIND_START) begin
         // A start aborts whatever dose is in progress.
         dstat_in = wds_pkg::ST_OK;
         ngc_in   = 3'd0;
         rc_in    = 3'd0;
         run_in   = '0;
         goal_in  = req.target_amount;
         if (!req.weight_valid) begin
            dstat_in   = wds_pkg::ST_NOSCALE;
            phase_in   = wds_pkg::PH_IDLE;
            rsp.action = wds_pkg::ACT_REPORT;
            rsp.status = wds_pkg::ST_NOSCALE;
         end else begin
            tare_in = req.weight;
            prev_in = req.weight;
            do_head = 1'b1;
         end
      end else if (req.kind == wds_pkg::KIND_TURN && phase_ff == wds_pkg::PH_DOSING) begin
         if (!req.weight_valid) begin
            dstat_in   = wds_pkg::ST_NOSCALE;
            phase_in   = wds_pkg::PH_FINAL;
            rsp.action = wds_pkg::ACT_STOP;
            rsp.status = wds_pkg::ST_NOSCALE;
         end else begin
            run_in  = gain_tare;
            prev_in = req.weight;
            do_head = 1'b1;
            if (gain_prev < min_gain_s) begin
               ngc_in = ngc_inc;
               if (ngc_inc >= cfg.stall_turns) begin
                  // Stalled long enough: reverse once, or give up past the limit.
                  ngc_in = 3'd0;
                  rc_in  = rc_inc[3] ? 3'd7 : rc_inc[2:0];
                  if (rc_inc > {1'b0, cfg.max_retracts}) begin
                     do_head    = 1'b0;
                     dstat_in   = wds_pkg::ST_NOFOOD;
                     phase_in   = wds_pkg::PH_FINAL;
                     rsp.action = wds_pkg::ACT_STOP;
                     rsp.status = wds_pkg::ST_NOFOOD;
                  end else begin
                     rev = 1'b1;
                  end
               end
            end else begin
               ngc_in = 3'd0;
            end
         end
      end else if (req.kind == wds_pkg::KIND_FINAL && phase_ff == wds_pkg::PH_FINAL) begin
         if (req.weight_valid) begin
            run_in = gain_tare;
         end
         phase_in   = wds_pkg::PH_IDLE;
         rsp.action = wds_pkg::ACT_REPORT;
         rsp.status = dstat_ff;
         // The running amount never exceeds the report width, so only zero clamps.
         rsp.delivered = (run_in <= 0) ? '0 : run_in[wds_pkg::DELIV_BITS-1:0];
      end

      if (do_head) begin
         rsp.reverse_first = rev;
         if (run_in >= $signed({2'b00, goal_in})) begin
            phase_in   = wds_pkg::PH_FINAL;
            rsp.action = wds_pkg::ACT_STOP;
            rsp.status = dstat_in;
         end else if (timed_out) begin
            dstat_in   = wds_pkg::ST_TIMEOUT;
            phase_in   = wds_pkg::PH_FINAL;
            rsp.action = wds_pkg::ACT_STOP;
            rsp.status = wds_pkg::ST_TIMEOUT;
         end else begin
            phase_in   = wds_pkg::PH_DOSING;
            rsp.action = wds_pkg::ACT_FORWARD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= wds_pkg::PH_IDLE;
         ngc_ff   <= 3'd0;
         rc_ff    <= 3'd0;
         dstat_ff <= wds_pkg::ST_OK;
      end else if (advance) begin
         phase_ff <= phase_in;
         ngc_ff   <= ngc_in;
         rc_ff    <= rc_in;
         dstat_ff <= dstat_in;
      end
   end

   // Weights and amounts are always rewritten by a start before they are used.
   always_ff @(posedge clock) begin
      if (advance) begin
         tare_ff <= tare_in;
         prev_ff <= prev_in;
         goal_ff <= goal_in;
         run_ff  <= run_in;
      end
   end

endmodule

// ===== rtl/core/weight_dosing_sequencer_core.sv =====
// Top level of the weight dosing sequencer.
`timescale 1ns / 1ps

// Closed-loop feeder dosing by weight. Requests arrive on the req_ channel:
// a start request carries the tare reading and the target, each later request
// carries the scale reading taken after one forward quarter-turn, and a final
// request carries the settled reading after the motor stops. For every request
// the rsp_ channel returns exactly one result: turn forward (with an optional
// half-turn reverse first), stop and take a final reading, or a dose report
// with status and delivered amount. Requests that do not fit the current phase
// return an all-zero result.
// A request is captured in an input register and decided as it moves into the
// output register, which raises rsp_valid; it moves on once the output register
// is free or emptying, so a stalled receiver can hold it in the input register.
// With every result taken, one request per cycle is sustained, since the state
// update is a single compare-and-subtract pass; the output register lets a new
// request enter while the previous result still waits. When the receiver
// stalls, the input register fills and then req_ready drops until rsp_ready
// returns. The csr_ channel is always ready; writes go to the register index
// given and are meant to happen while no request is in flight.
// Synchronous reset empties both registers, sets the phase to idle and loads
// the default configuration.
module weight_dosing_sequencer_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_kind,
   input  logic signed [wds_pkg::WEIGHT_BITS-1:0] req_weight,
   input  logic                                  req_weight_valid,
   input  logic [wds_pkg::GOAL_BITS-1:0]         req_target_amount,
   input  logic [wds_pkg::ELAPSED_BITS-1:0]      req_elapsed_ms,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [1:0]                            rsp_action,
   output logic                                  rsp_reverse_first,
   output logic [1:0]                            rsp_status,
   output logic [wds_pkg::DELIV_BITS-1:0]        rsp_delivered,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [wds_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [wds_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   wds_pkg::cfg_type cfg;
   wds_pkg::req_type req_ff;
   wds_pkg::rsp_type rsp_next;
   wds_pkg::rsp_type rsp_ff;
   logic             req_vld_ff, req_vld_in;
   logic             rsp_vld_ff, rsp_vld_in;
   logic             advance;
   logic             req_fire;

   // The held request moves on whenever the output register is free or emptying.
   assign advance   = req_vld_ff & (~rsp_vld_ff | rsp_ready);
   assign req_ready = ~req_vld_ff | advance;
   assign req_fire  = req_valid & req_ready;
   assign csr_ready = 1'b1;

   assign req_vld_in = req_fire | (req_vld_ff & ~advance);
   assign rsp_vld_in = advance | (rsp_vld_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= req_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff.kind          <= req_kind;
         req_ff.weight        <= req_weight;
         req_ff.weight_valid  <= req_weight_valid;
         req_ff.target_amount <= req_target_amount;
         req_ff.elapsed_ms    <= req_elapsed_ms;
      end
      if (advance) begin
         rsp_ff <= rsp_next;
      end
   end

   wds_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   wds_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (req_ff),
      .cfg     (cfg),
      .rsp     (rsp_next)
   );

   assign rsp_valid         = rsp_vld_ff;
   assign rsp_action        = rsp_ff.action;
   assign rsp_reverse_first = rsp_ff.reverse_first;
   assign rsp_status        = rsp_ff.status;
   assign rsp_delivered     = rsp_ff.delivered;

endmodule

// ===== rtl/core/wds_checker.sv =====
// Port-level checks on the result channel of the dosing sequencer.
`timescale 1ns / 1ps

module wds_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [1:0]                      rsp_action,
   input logic                            rsp_reverse_first,
   input logic [1:0]                      rsp_status,
   input logic [wds_pkg::DELIV_BITS-1:0]  rsp_delivered
);

   // A stalled result must hold.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_action) && $stable(rsp_status))
      else $error("result changed while stalled");

   // Nothing comes out in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // An ignored request gives an all-zero result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == wds_pkg::ACT_NONE
      |-> rsp_status == wds_pkg::ST_OK && !rsp_reverse_first && rsp_delivered == '0)
      else $error("ignored request with nonzero result");

   // Only a report carries a delivered amount.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action != wds_pkg::ACT_REPORT |-> rsp_delivered == '0)
      else $error("delivered amount outside a report");

   // A forward turn always goes with status ok.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == wds_pkg::ACT_FORWARD |-> rsp_status == wds_pkg::ST_OK)
      else $error("forward turn with error status");

endmodule

bind weight_dosing_sequencer_core wds_checker u_wds_checker (.*);

// ===== sim/dose_result_checker.sv =====
// Checker that predicts and compares every result of the weight dosing sequencer.
`timescale 1ns / 1ps

module dose_result_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_ready,
   input  logic [1:0]                             req_kind,
   input  logic signed [wds_pkg::WEIGHT_BITS-1:0] req_weight,
   input  logic                                   req_weight_valid,
   input  logic [wds_pkg::GOAL_BITS-1:0]          req_target_amount,
   input  logic [wds_pkg::ELAPSED_BITS-1:0]       req_elapsed_ms,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   input  logic [1:0]                             rsp_action,
   input  logic                                   rsp_reverse_first,
   input  logic [1:0]                             rsp_status,
   input  logic [wds_pkg::DELIV_BITS-1:0]         rsp_delivered,
   input  logic                                   csr_valid,
   input  logic                                   csr_ready,
   input  logic [wds_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [wds_pkg::CSR_DATA_BITS-1:0]      csr_wdata,
   output int                                     mismatch_count,
   output int                                     awaited_count,
   output int                                     acted_count,
   output int                                     ignored_count,
   output int                                     report_count,
   output int                                     reverse_count,
   output int                                     timeout_count,
   output int                                     nofood_count
);

   // Register copy.
   logic                              hopper_mode;
   logic [wds_pkg::SECONDS_BITS-1:0]  timeout_s;
   logic [wds_pkg::GOAL_BITS-1:0]     gain_floor;
   logic [2:0]                        stall_limit;
   logic [2:0]                        retract_limit;

   // Dose state copy.
   logic [1:0]                             dose_phase;
   logic signed [wds_pkg::WEIGHT_BITS-1:0] tare_reading;
   logic signed [wds_pkg::WEIGHT_BITS-1:0] last_reading;
   logic [wds_pkg::GOAL_BITS-1:0]          goal;
   logic signed [wds_pkg::DIFF_BITS-1:0]   fed_so_far;
   logic [2:0]                             no_gain_turns;
   logic [2:0]                             retracts;
   logic [1:0]                             dose_status;

   wds_pkg::rsp_type commands_due[$];
   int errors, acted, ignored, reports, reverses, timeouts, nofoods;

   initial begin
      errors = 0; acted = 0; ignored = 0; reports = 0;
      reverses = 0; timeouts = 0; nofoods = 0;
   end

   // Weight change seen as food delivered; a weighed hopper loses weight as it feeds.
   function automatic logic signed [wds_pkg::DIFF_BITS-1:0] food_moved(
      input logic signed [wds_pkg::WEIGHT_BITS-1:0] now_w,
      input logic signed [wds_pkg::WEIGHT_BITS-1:0] ref_w);
      logic signed [wds_pkg::DIFF_BITS-1:0] d;
      d = $signed({now_w[wds_pkg::WEIGHT_BITS-1], now_w})
          - $signed({ref_w[wds_pkg::WEIGHT_BITS-1], ref_w});
      return hopper_mode ? -d : d;
   endfunction

   // Stop once the goal is met or time has run out, otherwise turn forward.
   task automatic stop_or_turn(input logic [wds_pkg::ELAPSED_BITS-1:0] elapsed,
                               input logic rev, output wds_pkg::rsp_type res);
      logic [63:0] limit_ms;
      limit_ms = 64'(timeout_s) * 64'd1000;
      res = '0;
      res.reverse_first = rev;
      if (fed_so_far >= $signed({2'b00, goal})) begin
         dose_phase = wds_pkg::PH_FINAL;
         res.action = wds_pkg::ACT_STOP;
         res.status = dose_status;
      end else if (64'(elapsed) > limit_ms) begin
         dose_status = wds_pkg::ST_TIMEOUT;
         dose_phase = wds_pkg::PH_FINAL;
         res.action = wds_pkg::ACT_STOP;
         res.status = wds_pkg::ST_TIMEOUT;
      end else begin
         dose_phase = wds_pkg::PH_DOSING;
         res.action = wds_pkg::ACT_FORWARD;
      end
   endtask

   task automatic next_feeder_command(input wds_pkg::req_type r,
                                      output wds_pkg::rsp_type res);
      logic signed [wds_pkg::DIFF_BITS-1:0] gain;
      logic [3:0] retry;
      logic rev;
      res = '0;
      rev = 1'b0;
      if (r.kind == wds_pkg::KIND_START) begin
         dose_status = wds_pkg::ST_OK;
         no_gain_turns = '0;
         retracts = '0;
         fed_so_far = '0;
         goal = r.target_amount;
         if (!r.weight_valid) begin
            dose_status = wds_pkg::ST_NOSCALE;
            dose_phase = wds_pkg::PH_IDLE;
            res.action = wds_pkg::ACT_REPORT;
            res.status = wds_pkg::ST_NOSCALE;
         end else begin
            tare_reading = r.weight;
            last_reading = r.weight;
            stop_or_turn(r.elapsed_ms, 1'b0, res);
         end
      end else if (r.kind == wds_pkg::KIND_TURN && dose_phase == wds_pkg::PH_DOSING) begin
         if (!r.weight_valid) begin
            dose_status = wds_pkg::ST_NOSCALE;
            dose_phase = wds_pkg::PH_FINAL;
            res.action = wds_pkg::ACT_STOP;
            res.status = wds_pkg::ST_NOSCALE;
         end else begin
            gain = food_moved(r.weight, last_reading);
            fed_so_far = food_moved(r.weight, tare_reading);
            last_reading = r.weight;
            if (gain < $signed({2'b00, gain_floor})) begin
               no_gain_turns = no_gain_turns + 3'd1;
               if (no_gain_turns >= stall_limit) begin
                  retry = {1'b0, retracts} + 4'd1;
                  no_gain_turns = '0;
                  retracts = (retry > 4'd7) ? 3'd7 : retry[2:0];
                  if (retry > {1'b0, retract_limit}) begin
                     dose_status = wds_pkg::ST_NOFOOD;
                     dose_phase = wds_pkg::PH_FINAL;
                     res.action = wds_pkg::ACT_STOP;
                     res.status = wds_pkg::ST_NOFOOD;
                  end else begin
                     rev = 1'b1;
                  end
               end
            end else begin
               no_gain_turns = '0;
            end
            if (res.action == wds_pkg::ACT_NONE) begin
               stop_or_turn(r.elapsed_ms, rev, res);
            end
         end
      end else if (r.kind == wds_pkg::KIND_FINAL && dose_phase == wds_pkg::PH_FINAL) begin
         if (r.weight_valid) begin
            fed_so_far = food_moved(r.weight, tare_reading);
         end
         dose_phase = wds_pkg::PH_IDLE;
         res.action = wds_pkg::ACT_REPORT;
         res.status = dose_status;
         if (fed_so_far <= 0) begin
            res.delivered = '0;
         end else if (fed_so_far > $signed({1'b0, {wds_pkg::DELIV_BITS{1'b1}}})) begin
            res.delivered = '1;
         end else begin
            res.delivered = fed_so_far[wds_pkg::DELIV_BITS-1:0];
         end
      end
   endtask

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         errors++;
         $error("%s: expected %0d, got %0d", field, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      wds_pkg::rsp_type seen, want;
      wds_pkg::req_type request;
      if (reset) begin
         hopper_mode = 1'b0;
         timeout_s = wds_pkg::TIMEOUT_RESET;
         gain_floor = wds_pkg::MIN_GAIN_RESET;
         stall_limit = wds_pkg::STALL_RESET;
         retract_limit = wds_pkg::RETRACT_RESET;
         dose_phase = wds_pkg::PH_IDLE;
         tare_reading = '0;
         last_reading = '0;
         goal = '0;
         fed_so_far = '0;
         no_gain_turns = '0;
         retracts = '0;
         dose_status = wds_pkg::ST_OK;
         commands_due.delete();
      end else begin
         // Results leave before the request of this edge can have produced one.
         if (rsp_valid && rsp_ready) begin
            seen.action = rsp_action;
            seen.reverse_first = rsp_reverse_first;
            seen.status = rsp_status;
            seen.delivered = rsp_delivered;
            if (commands_due.size() == 0) begin
               errors++;
               $error("result with no request waiting: action %0d", seen.action);
            end else begin
               want = commands_due.pop_front();
               compare_field("action", want.action, seen.action);
               compare_field("reverse_first", want.reverse_first, seen.reverse_first);
               compare_field("status", want.status, seen.status);
               compare_field("delivered", want.delivered, seen.delivered);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               wds_pkg::CSR_SENSING_MODE: hopper_mode = csr_wdata[0];
               wds_pkg::CSR_TIMEOUT:      timeout_s = csr_wdata[wds_pkg::SECONDS_BITS-1:0];
               wds_pkg::CSR_MIN_GAIN:     gain_floor = csr_wdata[wds_pkg::GOAL_BITS-1:0];
               wds_pkg::CSR_STALL_TURNS:  stall_limit = csr_wdata[2:0];
               wds_pkg::CSR_MAX_RETRACTS: retract_limit = csr_wdata[2:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            request.kind = req_kind;
            request.weight = req_weight;
            request.weight_valid = req_weight_valid;
            request.target_amount = req_target_amount;
            request.elapsed_ms = req_elapsed_ms;
            next_feeder_command(request, want);
            commands_due.push_back(want);
            if (want.action == wds_pkg::ACT_NONE) ignored++;
            else acted++;
            if (want.reverse_first) reverses++;
            if (want.action == wds_pkg::ACT_REPORT) begin
               reports++;
               if (want.status == wds_pkg::ST_TIMEOUT) timeouts++;
               if (want.status == wds_pkg::ST_NOFOOD) nofoods++;
            end
         end
      end
      mismatch_count <= errors;
      awaited_count <= commands_due.size();
      acted_count <= acted;
      ignored_count <= ignored;
      report_count <= reports;
      reverse_count <= reverses;
      timeout_count <= timeouts;
      nofood_count <= nofoods;
   end

endmodule

// ===== sim/testbench.sv =====
// Top of the weight dosing sequencer testbench: stimulus, pacing, watchdog and verdict.
`timescale 1ns / 1ps

module testbench;

   // The watchdog gives up after this many cycles without any handshake. The
   // longest legal quiet stretch is a random run of receiver or sender idling,
   // which at 73 percent never comes near this.
   localparam int WATCHDOG_LIMIT = 4000;
   // Each of the eighteen random blocks runs doses until this many more
   // requests have been sent, which puts the whole run near 1550 requests.
   localparam int BLOCK_REQUESTS = 86;
   // Kind code that the block does not know and must ignore.
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam logic signed [wds_pkg::WEIGHT_BITS-1:0] LIGHTEST = 24'sh800000;
   localparam logic signed [wds_pkg::WEIGHT_BITS-1:0] HEAVIEST = 24'sh7FFFFF;
   localparam logic [wds_pkg::GOAL_BITS-1:0] GOAL_MAX = {wds_pkg::GOAL_BITS{1'b1}};

   logic clock;
   logic reset = 1'b1;

   logic                                   req_valid = 1'b0;
   logic                                   req_ready;
   logic [1:0]                             req_kind = wds_pkg::KIND_START;
   logic signed [wds_pkg::WEIGHT_BITS-1:0] req_weight = '0;
   logic                                   req_weight_valid = 1'b0;
   logic [wds_pkg::GOAL_BITS-1:0]          req_target_amount = '0;
   logic [wds_pkg::ELAPSED_BITS-1:0]       req_elapsed_ms = '0;
   logic                                   rsp_valid;
   logic                                   rsp_ready = 1'b0;
   logic [1:0]                             rsp_action;
   logic                                   rsp_reverse_first;
   logic [1:0]                             rsp_status;
   logic [wds_pkg::DELIV_BITS-1:0]         rsp_delivered;
   logic                                   csr_valid = 1'b0;
   logic                                   csr_ready;
   logic [wds_pkg::CSR_INDEX_BITS-1:0]     csr_index = wds_pkg::CSR_SENSING_MODE;
   logic [wds_pkg::CSR_DATA_BITS-1:0]      csr_wdata = '0;

   int mismatch_count, awaited_count, acted_count, ignored_count;
   int report_count, reverse_count, timeout_count, nofood_count;

   // Pacing, in percent of cycles in which each side holds back.
   int send_gap_pct = 31;
   int drain_stall_pct = 73;
   int quiet_cycles = 0;

   // Settings last written; the stimulus uses them to shape plausible doses.
   logic   cur_hopper = 1'b0;
   longint cur_min_gain = 50;
   longint cur_limit_ms = 60000;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   weight_dosing_sequencer_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_weight        (req_weight),
      .req_weight_valid  (req_weight_valid),
      .req_target_amount (req_target_amount),
      .req_elapsed_ms    (req_elapsed_ms),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_action        (rsp_action),
      .rsp_reverse_first (rsp_reverse_first),
      .rsp_status        (rsp_status),
      .rsp_delivered     (rsp_delivered),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // The checker sees every handshake, keeps its own copy of the dose state,
   // and compares each result with the command it expects.
   dose_result_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_weight        (req_weight),
      .req_weight_valid  (req_weight_valid),
      .req_target_amount (req_target_amount),
      .req_elapsed_ms    (req_elapsed_ms),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_action        (rsp_action),
      .rsp_reverse_first (rsp_reverse_first),
      .rsp_status        (rsp_status),
      .rsp_delivered     (rsp_delivered),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .mismatch_count    (mismatch_count),
      .awaited_count     (awaited_count),
      .acted_count       (acted_count),
      .ignored_count     (ignored_count),
      .report_count      (report_count),
      .reverse_count     (reverse_count),
      .timeout_count     (timeout_count),
      .nofood_count      (nofood_count)
   );

   // The receiver decides afresh at every edge whether it takes a result.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= drain_stall_pct);
   end

   // Any accepted request, result or register write counts as progress.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one request and returns at the edge that accepts it. Valid is left
   // high so that a following request can go out back to back; an idle gap
   // lowers it first.
   task automatic send_request(input logic [1:0] kind,
                               input logic signed [wds_pkg::WEIGHT_BITS-1:0] weight,
                               input logic weight_ok,
                               input logic [wds_pkg::GOAL_BITS-1:0] target,
                               input logic [wds_pkg::ELAPSED_BITS-1:0] elapsed);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_weight <= weight;
      req_weight_valid <= weight_ok;
      req_target_amount <= target;
      req_elapsed_ms <= elapsed;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_register(input logic [wds_pkg::CSR_INDEX_BITS-1:0] index,
                                 input logic [wds_pkg::CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic write_settings(input logic mode,
                                 input logic [wds_pkg::SECONDS_BITS-1:0] seconds,
                                 input logic [wds_pkg::GOAL_BITS-1:0] gain,
                                 input logic [2:0] stall,
                                 input logic [2:0] retract);
      write_register(wds_pkg::CSR_SENSING_MODE, wds_pkg::CSR_DATA_BITS'(mode));
      write_register(wds_pkg::CSR_TIMEOUT, wds_pkg::CSR_DATA_BITS'(seconds));
      write_register(wds_pkg::CSR_MIN_GAIN, gain);
      write_register(wds_pkg::CSR_STALL_TURNS, wds_pkg::CSR_DATA_BITS'(stall));
      write_register(wds_pkg::CSR_MAX_RETRACTS, wds_pkg::CSR_DATA_BITS'(retract));
      csr_valid <= 1'b0;
      cur_hopper = mode;
      cur_min_gain = gain;
      cur_limit_ms = longint'(seconds) * 1000;
   endtask

   // Stops offering requests and waits until every expected result is back.
   // Every request produces exactly one result, so an empty checker queue
   // means the block is idle and may be reconfigured.
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_count != 0) @(posedge clock);
   endtask

   function automatic longint clamp_reading(input longint w);
      if (w > longint'(HEAVIEST)) return longint'(HEAVIEST);
      if (w < longint'(LIGHTEST)) return longint'(LIGHTEST);
      return w;
   endfunction

   // One dose as a feeder controller would run it: a start with the tare,
   // forward-turn readings until the food given reaches the target, and a
   // settled final reading. Some doses are jammed, so most turns bring no
   // gain and the block has to reverse and eventually give up. A few doses
   // carry a stray request in front, lose the scale, or are cut short by the
   // next start.
   task automatic run_dose();
      longint reading, fed, delta_w, typical;
      logic [wds_pkg::ELAPSED_BITS-1:0] dose_ms;
      logic [wds_pkg::GOAL_BITS-1:0] target;
      logic start_ok, jammed, reading_ok;
      int pick, turns;
      if ($urandom_range(99) < 8) begin
         send_request(2'($urandom_range(3)), 24'($urandom), 1'($urandom_range(1)),
                      23'($urandom), $urandom);
      end
      typical = cur_min_gain + 100;
      if ($urandom_range(99) < 25) reading = longint'($signed(24'($urandom)));
      else reading = longint'($urandom_range(200000)) - 100000;

      pick = $urandom_range(99);
      fed = typical * longint'($urandom_range(1, 12));
      if (pick < 5) target = '0;
      else if (pick < 12) target = 23'($urandom);
      else target = (fed > longint'(GOAL_MAX)) ? GOAL_MAX : 23'(fed);

      // Some starts come already past the time limit.
      pick = $urandom_range(99);
      if (pick < 20) dose_ms = '0;
      else if (pick < 26) dose_ms = 32'(cur_limit_ms + 1 + longint'($urandom_range(500)));
      else dose_ms = $urandom_range(2000);

      start_ok = ($urandom_range(99) >= 5);
      send_request(wds_pkg::KIND_START, 24'(reading), start_ok, target, dose_ms);
      if (!start_ok) return;

      jammed = ($urandom_range(99) < 30);
      fed = 0;
      reading_ok = 1'b1;
      turns = 0;
      while (reading_ok && turns < 60 && !(fed >= target && $urandom_range(99) < 85)) begin
         pick = $urandom_range(99);
         delta_w = 0;
         if (pick < 4) begin
            reading_ok = 1'b0;
         end else if (pick < (jammed ? 92 : 35)) begin
            // Too little to count as progress, sometimes a small loss.
            delta_w = longint'($urandom_range(32'(cur_min_gain))) - longint'($urandom_range(40));
         end else if (pick < 97) begin
            delta_w = cur_min_gain + longint'($urandom_range(32'(typical)));
         end else begin
            delta_w = longint'($signed(24'($urandom)));
         end
         reading = clamp_reading(reading + (cur_hopper ? -delta_w : delta_w));
         fed += delta_w;
         dose_ms = dose_ms + $urandom_range(100, 3000);
         if ($urandom_range(99) < 3) dose_ms = dose_ms + 32'(cur_limit_ms);
         send_request(wds_pkg::KIND_TURN, 24'(reading), reading_ok, 23'($urandom), dose_ms);
         turns++;
      end

      if ($urandom_range(99) < 85) begin
         reading = clamp_reading(reading + longint'($urandom_range(60)) - 30);
         send_request(wds_pkg::KIND_FINAL, 24'(reading), ($urandom_range(99) >= 10),
                      23'($urandom), dose_ms + $urandom_range(2000));
      end
   endtask

   initial begin : stimulus
      int block_goal;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part, under the reset settings: spout scale, 60 s limit,
      // 0.5 g floor, four stalled turns per reverse, three reverses allowed.

      // A start without a scale reports at once.
      send_request(wds_pkg::KIND_START, LIGHTEST, 1'b0, GOAL_MAX, 32'd0);
      // A zero goal stops right away; the final reading below the tare
      // reports nothing delivered.
      send_request(wds_pkg::KIND_START, 24'sd1000, 1'b1, 23'd0, 32'd0);
      send_request(wds_pkg::KIND_FINAL, 24'sd500, 1'b1, 23'd0, 32'd0);
      // Already past the time limit at start; the final reading is missing.
      send_request(wds_pkg::KIND_START, 24'sd0, 1'b1, 23'd100, 32'hFFFF_FFFF);
      send_request(wds_pkg::KIND_FINAL, 24'sd0, 1'b0, 23'd0, 32'd0);
      // Requests that do not fit the idle phase, and an unknown kind.
      send_request(wds_pkg::KIND_TURN, HEAVIEST, 1'b1, GOAL_MAX, 32'd10);
      send_request(wds_pkg::KIND_FINAL, HEAVIEST, 1'b1, GOAL_MAX, 32'd10);
      send_request(KIND_UNUSED, HEAVIEST, 1'b1, GOAL_MAX, 32'hFFFF_FFFF);
      // Full swing of the scale: the report reaches its widest value.
      send_request(wds_pkg::KIND_START, LIGHTEST, 1'b1, GOAL_MAX, 32'd0);
      send_request(wds_pkg::KIND_TURN, HEAVIEST, 1'b1, 23'd0, 32'd1000);
      send_request(wds_pkg::KIND_FINAL, HEAVIEST, 1'b1, 23'd0, 32'd2000);
      // Turns without gain, then the scale drops out mid-dose; the report
      // falls back on the last amount seen.
      send_request(wds_pkg::KIND_START, 24'sd0, 1'b1, 23'd1000, 32'd0);
      send_request(wds_pkg::KIND_TURN, 24'sd10, 1'b1, 23'd0, 32'd500);
      send_request(wds_pkg::KIND_TURN, 24'sd20, 1'b1, 23'd0, 32'd1000);
      send_request(wds_pkg::KIND_TURN, 24'sd5, 1'b1, 23'd0, 32'd1500);
      send_request(wds_pkg::KIND_TURN, 24'sd0, 1'b0, 23'd0, 32'd2000);
      send_request(wds_pkg::KIND_FINAL, 24'sd0, 1'b0, 23'd0, 32'd2500);
      // A start while dosing aborts the dose. Then the fourth slow turn both
      // reaches the goal and asks for a reverse, which goes out with the stop.
      send_request(wds_pkg::KIND_START, 24'sd0, 1'b1, 23'd40, 32'd0);
      send_request(wds_pkg::KIND_TURN, 24'sd10, 1'b1, 23'd0, 32'd500);
      send_request(wds_pkg::KIND_START, 24'sd0, 1'b1, 23'd40, 32'd0);
      send_request(wds_pkg::KIND_TURN, 24'sd10, 1'b1, 23'd0, 32'd500);
      send_request(wds_pkg::KIND_TURN, 24'sd20, 1'b1, 23'd0, 32'd1000);
      send_request(wds_pkg::KIND_TURN, 24'sd30, 1'b1, 23'd0, 32'd1500);
      send_request(wds_pkg::KIND_TURN, 24'sd40, 1'b1, 23'd0, 32'd2000);
      send_request(wds_pkg::KIND_FINAL, 24'sd45, 1'b1, 23'd0, 32'd2500);
      wait_until_idle();

      // Random part: three pacings, each running through six register
      // settings that include both ends of every register.
      for (int pacing = 0; pacing < 3; pacing++) begin
         case (pacing)
            0: begin
               send_gap_pct <= 31;
               drain_stall_pct <= 73;
            end
            1: begin
               send_gap_pct <= 73;
               drain_stall_pct <= 31;
            end
            default: begin
               send_gap_pct <= 0;
               drain_stall_pct <= 0;
            end
         endcase
         for (int preset = 0; preset < 6; preset++) begin
            case (preset)
               0: write_settings(1'b1, 16'd60, 23'd50, 3'd4, 3'd3);
               // No time at all, no floor, a reverse after every stall and none allowed.
               1: write_settings(1'b0, 16'd0, 23'd0, 3'd1, 3'd0);
               // Widest values of every register but the retract limit.
               2: write_settings(1'b1, 16'd65535, GOAL_MAX, 3'd7, 3'd6);
               // Zero stall count reverses on every slow turn; the retract
               // limit sits where the counter saturates.
               3: write_settings(1'b0, 16'd5, 23'd200, 3'd0, 3'd7);
               4: write_settings(1'b1, 16'd30, 23'd20, 3'd2, 3'd1);
               default: write_settings(1'b0, 16'd60, 23'd50, 3'd4, 3'd3);
            endcase
            block_goal = acted_count + ignored_count + BLOCK_REQUESTS;
            while (acted_count + ignored_count < block_goal) run_dose();
            wait_until_idle();
         end
      end

      // Let any stray result show up before the verdict.
      repeat (8) @(posedge clock);
      $display("Ran %0d requests (%0d ignored by the block) over six register settings",
               acted_count + ignored_count, ignored_count);
      $display("and three pacings: %0d reports, %0d reverses, %0d timeouts, %0d no-food ends.",
               report_count, reverse_count, timeout_count, nofood_count);
      if (mismatch_count == 0 && awaited_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/wds_pkg.sv
rtl/core/wds_csr.sv
rtl/core/wds_ctrl.sv
rtl/core/weight_dosing_sequencer_core.sv
rtl/core/wds_checker.sv
sim/dose_result_checker.sv
sim/testbench.sv
